// ===== hw/rtl/lpcb_pkg.sv =====
package lpcb_pkg;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_LEVEL = 2'd2;

  localparam logic [7:0] ADDR_ACPI_LO = 8'h40;
  localparam logic [7:0] ADDR_ACPI_HI = 8'h41;
  localparam logic [7:0] ADDR_ACPI_EN = 8'h44;
  localparam logic [7:0] ADDR_LOCK    = 8'h4e;
  localparam logic [7:0] ADDR_GPIO_LO = 8'h58;
  localparam logic [7:0] ADDR_GPIO_HI = 8'h59;
  localparam logic [7:0] ADDR_GPIO_EN = 8'h5c;
  localparam logic [7:0] ADDR_CMOS    = 8'hd8;

  // ISA IRQs a routing nibble may select: 3-7, 9-12, 14, 15
  localparam logic [15:0] VALID_ISA = 16'hdef8;

  localparam logic [7:0] ROUTE_RESET = 8'h80;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] reg_address;
    logic [7:0] write_byte;
    logic [2:0] line_index;
    logic       line_level;
  } lpcb_in_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [15:0] isa_irq_levels;
    logic [7:0]  apic_line_levels;
    logic [15:0] acpi_base;
    logic        acpi_enable;
    logic [15:0] gpio_base;
    logic        gpio_enable;
    logic        cmos_upper_enable;
    logic        cmos_lower_lock;
    logic        cmos_upper_lock;
  } lpcb_out_t;

  // Copies of the config bytes that drive status outputs and routing
  typedef struct packed {
    logic [7:0][7:0] route;
    logic            acpi_lo;
    logic [7:0]      acpi_hi;
    logic            acpi_en;
    logic            lock_4e;
    logic [1:0]      gpio_lo;
    logic [7:0]      gpio_hi;
    logic            gpio_en;
    logic            cmos_upper_en;
    logic            cmos_lower_lock;
    logic            cmos_upper_lock;
  } lpcb_state_t;

  function automatic logic [7:0] write_mask(input logic [7:0] addr);
    logic [7:0] m;
    unique case (addr)
      8'h40: m = 8'h80;
      8'h41: m = 8'hff;
      8'h44: m = 8'h17;
      8'h4e: m = 8'h03;
      8'h54: m = 8'h0f;
      8'h58: m = 8'hc0;
      8'h59: m = 8'hff;
      8'h5c: m = 8'h10;
      8'h60, 8'h61, 8'h62, 8'h63: m = 8'h8f;
      8'h64: m = 8'hff;
      8'h68, 8'h69, 8'h6a, 8'h6b: m = 8'h8f;
      8'h88: m = 8'h06;
      8'h8a: m = 8'h06;
      8'h90: m = 8'hff;
      8'h91: m = 8'hfc;
      8'ha0: m = 8'h33;
      8'ha2: m = 8'h7b;
      8'ha4: m = 8'hc8;
      8'ha8: m = 8'h3f;
      8'hb8, 8'hb9, 8'hba, 8'hbb: m = 8'hff;
      8'hc0: m = 8'hf0;
      8'hc4, 8'hc5, 8'hc6, 8'hc7: m = 8'hff;
      8'hc8, 8'hc9, 8'hca, 8'hcb: m = 8'hff;
      8'hcc, 8'hcd: m = 8'hff;
      8'hd0: m = 8'hc7;
      8'hd1: m = 8'h39;
      8'hd2: m = 8'h20;
      8'hd3: m = 8'h03;
      8'hd4: m = 8'h02;
      8'hd5: m = 8'h3f;
      8'hd8: m = 8'h1c;
      8'he0: m = 8'h77;
      8'he1: m = 8'h13;
      8'he2: m = 8'h3b;
      8'he3: m = 8'hff;
      8'he4: m = 8'h81;
      8'he5, 8'he6: m = 8'hff;
      8'he7: m = 8'h3f;
      8'he8, 8'he9, 8'hea, 8'heb: m = 8'hff;
      8'hec: m = 8'hf1;
      8'hed, 8'hee, 8'hef: m = 8'hff;
      8'hf0: m = 8'h0f;
      8'hf2: m = 8'h6b;
      8'hf3: m = 8'hc7;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] reset_byte(input logic [7:0] addr);
    logic [7:0] v;
    unique case (addr)
      8'h40, 8'h58: v = 8'h01;
      8'h60, 8'h61, 8'h62, 8'h63: v = ROUTE_RESET;
      8'h68, 8'h69, 8'h6a, 8'h6b: v = ROUTE_RESET;
      8'ha8: v = 8'h0d;
      8'he3: v = 8'hff;
      8'he9: v = 8'h33;
      8'hea: v = 8'h22;
      8'heb: v = 8'h11;
      8'hee: v = 8'h78;
      8'hef: v = 8'h56;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/lpc_bridge_config_and_pirq_router.sv =====
// LPC bridge configuration space and PCI interrupt router.
// Input channel in_valid/in_ready/in_data carries one request per transfer:
// a config byte write, a config byte read, or a level change of one of the
// eight PCI interrupt lines. Every request yields exactly one result on
// out_valid/out_ready/out_data: read data (zero unless a read), ISA IRQ and
// APIC line levels, ACPI and GPIO base/enable and the CMOS lock flags, all
// taken from the state after that request.
// out_valid rises once a request has passed the request register and then
// the output register. One request per cycle is sustained while out_ready
// is high: the request register and the output register form a two-stage
// pipe; config writes, reads and level updates are done at acceptance.
// Reset restores the default config bytes at once (bytes never written
// read their default), clears line levels and CMOS flags; no sweep needed.
// While the receiver stalls the output register holds its result, the
// request stage still takes one more request, then in_ready drops.
module lpc_bridge_config_and_pirq_router import lpcb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lpcb_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lpcb_out_t out_data
);

  logic        accept;
  logic        b_move;
  logic        b_valid_r;
  logic        b_valid_nxt;
  logic        b_is_read_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  lpcb_out_t   out_data_r;
  lpcb_out_t   result;
  logic [7:0]  rd_byte;
  logic [15:0] isa_levels;
  logic [7:0]  apic_levels;
  lpcb_state_t state;

  assign b_move   = b_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !b_valid_r || !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  lpcb_cfg_space u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .req     (in_data),
    .rd_byte (rd_byte),
    .state   (state)
  );

  lpcb_pirq_router u_router (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req         (in_data),
    .route       (state.route),
    .isa_levels  (isa_levels),
    .apic_levels (apic_levels)
  );

  always_comb begin
    result.read_byte         = b_is_read_r ? rd_byte : 8'h00;
    result.isa_irq_levels    = isa_levels;
    result.apic_line_levels  = apic_levels;
    result.acpi_base         = {state.acpi_hi, state.acpi_lo, 7'b0};
    result.acpi_enable       = state.acpi_en;
    result.gpio_base         = {state.gpio_hi, state.gpio_lo, 6'b0};
    result.gpio_enable       = state.gpio_en;
    result.cmos_upper_enable = state.cmos_upper_en;
    result.cmos_lower_lock   = state.cmos_lower_lock;
    result.cmos_upper_lock   = state.cmos_upper_lock;
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (accept) begin
      b_valid_nxt = 1'b1;
    end else if (b_move) begin
      b_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (b_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_is_read_r <= (in_data.req_type == REQ_READ);
    end
    if (b_move) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/lpcb_cfg_space.sv =====
module lpcb_cfg_space import lpcb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  lpcb_in_t    req,
  output logic [7:0]  rd_byte,
  output lpcb_state_t state
);

  logic [7:0]   mem_r [256];
  logic [255:0] written_r;
  logic [255:0] written_nxt;
  logic [7:0]   rd_data_r;
  logic         rd_hit_r;
  logic [7:0]   rd_addr_r;
  lpcb_state_t  state_r;
  lpcb_state_t  state_nxt;
  logic [7:0]   mask;
  logic [7:0]   wdata;
  logic         wr_en;

  assign mask  = write_mask(req.reg_address);
  assign wdata = req.write_byte & mask;
  // 0x4E freezes once its bit 1 is set
  assign wr_en = accept && (req.req_type == REQ_WRITE) && (mask != 8'h00) &&
                 !((req.reg_address == ADDR_LOCK) && state_r.lock_4e);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[req.reg_address] <= wdata;
    end
    if (accept) begin
      rd_data_r <= mem_r[req.reg_address];
      rd_addr_r <= req.reg_address;
    end
  end

  // Never-written bytes read as their reset value
  always_comb begin
    written_nxt = written_r;
    if (wr_en) begin
      written_nxt[req.reg_address] = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (wr_en) begin
      unique case (req.reg_address)
        ADDR_ACPI_LO: state_nxt.acpi_lo = wdata[7];
        ADDR_ACPI_HI: state_nxt.acpi_hi = wdata;
        ADDR_ACPI_EN: state_nxt.acpi_en = wdata[4];
        ADDR_LOCK:    state_nxt.lock_4e = wdata[1];
        ADDR_GPIO_LO: state_nxt.gpio_lo = wdata[7:6];
        ADDR_GPIO_HI: state_nxt.gpio_hi = wdata;
        ADDR_GPIO_EN: state_nxt.gpio_en = wdata[4];
        ADDR_CMOS: begin
          state_nxt.cmos_upper_en   = wdata[2];
          state_nxt.cmos_lower_lock = state_r.cmos_lower_lock | wdata[3];
          state_nxt.cmos_upper_lock = state_r.cmos_upper_lock | wdata[4];
        end
        8'h60, 8'h61, 8'h62, 8'h63, 8'h68, 8'h69, 8'h6a, 8'h6b: begin
          state_nxt.route[{req.reg_address[3], req.reg_address[1:0]}] = wdata;
        end
        default: state_nxt = state_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_hit_r  <= 1'b0;
      state_r   <= '{route: {8{ROUTE_RESET}}, default: '0};
    end else begin
      written_r <= written_nxt;
      state_r   <= state_nxt;
      if (accept) begin
        rd_hit_r <= written_r[req.reg_address];
      end
    end
  end

  assign rd_byte = rd_hit_r ? rd_data_r : reset_byte(rd_addr_r);
  assign state   = state_r;

endmodule

// ===== hw/rtl/lpcb_pirq_router.sv =====
module lpcb_pirq_router import lpcb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  lpcb_in_t        req,
  input  logic [7:0][7:0] route,
  output logic [15:0]     isa_levels,
  output logic [7:0]      apic_levels
);

  logic [7:0] level_r;
  logic [7:0] level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (accept && (req.req_type == REQ_LEVEL)) begin
      level_nxt[req.line_index] = req.line_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  // bit 7 clear and a legal nibble steers a line to ISA, else to the APIC
  always_comb begin
    isa_levels  = '0;
    apic_levels = '0;
    for (int i = 0; i < 8; i++) begin
      if (!route[i][7] && VALID_ISA[route[i][3:0]]) begin
        if (level_r[i]) begin
          isa_levels[route[i][3:0]] = 1'b1;
        end
      end else begin
        apic_levels[i] = level_r[i];
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import lpcb_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1530;
  localparam int QUIET_TAIL = 150;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    lpcb_in_t   item;
    bit         typed;
    logic [7:0] rd;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  lpcb_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  lpcb_out_t out_data;

  lpc_bridge_config_and_pirq_router dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // mirror of the bridge state
  logic [7:0] cfg_mirror [256];
  logic [7:0] wmask [256];
  logic [7:0] line_mirror;
  logic [2:0] cmos_mirror;

  lpcb_out_t pending_results [$];
  stim_row_t directed_rows [$];
  int        fail_count;
  bit        quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // lines A-D at 0x60-0x63, E-H at 0x68-0x6B
  function automatic logic [7:0] route_addr(input logic [2:0] line);
    return {4'b0110, line[2], 1'b0, line[1:0]};
  endfunction

  initial begin
    foreach (wmask[a]) wmask[a] = 8'h00;
    wmask[ADDR_ACPI_LO] = 8'h80;
    wmask[ADDR_ACPI_HI] = 8'hff;
    wmask[ADDR_ACPI_EN] = 8'h17;
    wmask[ADDR_LOCK]    = 8'h03;
    wmask[8'h54]        = 8'h0f;
    wmask[ADDR_GPIO_LO] = 8'hc0;
    wmask[ADDR_GPIO_HI] = 8'hff;
    wmask[ADDR_GPIO_EN] = 8'h10;
    for (int i = 0; i < 8; i++) wmask[route_addr(i)] = 8'h8f;
    wmask[8'h64] = 8'hff;
    wmask[8'h88] = 8'h06;
    wmask[8'h8a] = 8'h06;
    wmask[8'h90] = 8'hff;
    wmask[8'h91] = 8'hfc;
    wmask[8'ha0] = 8'h33;
    wmask[8'ha2] = 8'h7b;
    wmask[8'ha4] = 8'hc8;
    wmask[8'ha8] = 8'h3f;
    for (int a = 8'hb8; a <= 8'hbb; a++) wmask[a] = 8'hff;
    wmask[8'hc0] = 8'hf0;
    for (int a = 8'hc4; a <= 8'hcd; a++) wmask[a] = 8'hff;
    wmask[8'hd0] = 8'hc7;
    wmask[8'hd1] = 8'h39;
    wmask[8'hd2] = 8'h20;
    wmask[8'hd3] = 8'h03;
    wmask[8'hd4] = 8'h02;
    wmask[8'hd5] = 8'h3f;
    wmask[ADDR_CMOS] = 8'h1c;
    wmask[8'he0] = 8'h77;
    wmask[8'he1] = 8'h13;
    wmask[8'he2] = 8'h3b;
    wmask[8'he3] = 8'hff;
    wmask[8'he4] = 8'h81;
    wmask[8'he5] = 8'hff;
    wmask[8'he6] = 8'hff;
    wmask[8'he7] = 8'h3f;
    for (int a = 8'he8; a <= 8'heb; a++) wmask[a] = 8'hff;
    wmask[8'hec] = 8'hf1;
    for (int a = 8'hed; a <= 8'hef; a++) wmask[a] = 8'hff;
    wmask[8'hf0] = 8'h0f;
    wmask[8'hf2] = 8'h6b;
    wmask[8'hf3] = 8'hc7;
  end

  // advance the mirror by one request and return the status it should show
  function automatic lpcb_out_t predict_status(input lpcb_in_t t);
    lpcb_out_t  r;
    logic [7:0] m;
    logic [7:0] rb;
    logic [3:0] irq;
    r = '0;
    case (t.req_type)
      REQ_WRITE: begin
        m = wmask[t.reg_address];
        if (m != 8'h00 && !(t.reg_address == ADDR_LOCK && cfg_mirror[ADDR_LOCK][1])) begin
          cfg_mirror[t.reg_address] = t.write_byte & m;
          if (t.reg_address == ADDR_CMOS) begin
            rb = cfg_mirror[ADDR_CMOS];
            cmos_mirror[0] = rb[2];
            cmos_mirror[1] = cmos_mirror[1] | rb[3];
            cmos_mirror[2] = cmos_mirror[2] | rb[4];
          end
        end
      end
      REQ_READ:  r.read_byte = cfg_mirror[t.reg_address];
      REQ_LEVEL: line_mirror[t.line_index] = t.line_level;
      default: ;
    endcase
    for (int i = 0; i < 8; i++) begin
      rb  = cfg_mirror[route_addr(i)];
      irq = rb[3:0];
      if (!rb[7] && VALID_ISA[irq]) begin
        if (line_mirror[i]) r.isa_irq_levels[irq] = 1'b1;
      end else if (line_mirror[i]) begin
        r.apic_line_levels[i] = 1'b1;
      end
    end
    r.acpi_base = {cfg_mirror[ADDR_ACPI_HI], cfg_mirror[ADDR_ACPI_LO] & 8'h80} & 16'hffc0;
    r.acpi_enable = cfg_mirror[ADDR_ACPI_EN][4];
    r.gpio_base = {cfg_mirror[ADDR_GPIO_HI], cfg_mirror[ADDR_GPIO_LO] & 8'hc0};
    r.gpio_enable = cfg_mirror[ADDR_GPIO_EN][4];
    r.cmos_upper_enable = cmos_mirror[0];
    r.cmos_lower_lock = cmos_mirror[1];
    r.cmos_upper_lock = cmos_mirror[2];
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] req, input logic [7:0] addr,
                                  input logic [7:0] wb, input logic [2:0] line,
                                  input logic lvl, input bit typed, input logic [7:0] rd);
    stim_row_t row;
    row.item  = '{req_type: req, reg_address: addr, write_byte: wb,
                  line_index: line, line_level: lvl};
    row.typed = typed;
    row.rd    = rd;
    directed_rows.push_back(row);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_transfer(input lpcb_in_t item, input bit typed, input logic [7:0] rd);
    int        gap;
    lpcb_out_t status;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    status = predict_status(item);
    if (typed) status.read_byte = rd;
    pending_results.push_back(status);
    @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    lpcb_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: %h", out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("read_byte", want.read_byte, out_data.read_byte);
        compare_field("isa_irq_levels", want.isa_irq_levels, out_data.isa_irq_levels);
        compare_field("apic_line_levels", want.apic_line_levels, out_data.apic_line_levels);
        compare_field("acpi_base", want.acpi_base, out_data.acpi_base);
        compare_field("acpi_enable", want.acpi_enable, out_data.acpi_enable);
        compare_field("gpio_base", want.gpio_base, out_data.gpio_base);
        compare_field("gpio_enable", want.gpio_enable, out_data.gpio_enable);
        compare_field("cmos_upper_enable", want.cmos_upper_enable,
                      out_data.cmos_upper_enable);
        compare_field("cmos_lower_lock", want.cmos_lower_lock, out_data.cmos_lower_lock);
        compare_field("cmos_upper_lock", want.cmos_upper_lock, out_data.cmos_upper_lock);
      end
    end
  end

  // receiver back-pressure, with calm stretches
  initial begin
    int hold;
    int calm;
    out_ready = 1'b0;
    hold = 0;
    calm = 0;
    forever begin
      @(negedge clk);
      if (calm > 0) calm--;
      else if ($urandom_range(0, 15) == 0) calm = $urandom_range(20, 80);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (!quiet && calm == 0 && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    lpcb_in_t   t;
    logic [7:0] hot [$];
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    quiet      = 1'b0;
    fail_count = 0;

    foreach (cfg_mirror[a]) cfg_mirror[a] = 8'h00;
    cfg_mirror[ADDR_ACPI_LO] = 8'h01;
    cfg_mirror[ADDR_GPIO_LO] = 8'h01;
    for (int i = 0; i < 8; i++) cfg_mirror[route_addr(i)] = ROUTE_RESET;
    cfg_mirror[8'ha8] = 8'h0d;
    cfg_mirror[8'he3] = 8'hff;
    cfg_mirror[8'he9] = 8'h33;
    cfg_mirror[8'hea] = 8'h22;
    cfg_mirror[8'heb] = 8'h11;
    cfg_mirror[8'hee] = 8'h78;
    cfg_mirror[8'hef] = 8'h56;
    line_mirror = 8'h00;
    cmos_mirror = 3'b000;

    //      req        addr          wbyte  line  lvl typed rd
    add_row(REQ_READ,  ADDR_ACPI_LO, 8'h00, 3'd0, 0, 1, 8'h01);
    add_row(REQ_READ,  8'he3,        8'h00, 3'd0, 0, 1, 8'hff);
    add_row(REQ_READ,  8'h00,        8'hff, 3'd7, 1, 1, 8'h00);
    add_row(REQ_READ,  8'hff,        8'h00, 3'd0, 0, 1, 8'h00);
    add_row(REQ_WRITE, 8'h00,        8'hff, 3'd0, 0, 0, 8'h00);  // read-only byte
    add_row(REQ_READ,  8'h00,        8'h00, 3'd0, 0, 1, 8'h00);
    add_row(REQ_WRITE, ADDR_ACPI_HI, 8'hff, 3'd0, 0, 0, 8'h00);
    add_row(REQ_WRITE, ADDR_ACPI_LO, 8'hff, 3'd0, 0, 0, 8'h00);
    add_row(REQ_READ,  ADDR_ACPI_LO, 8'h00, 3'd0, 0, 1, 8'h80);
    add_row(REQ_WRITE, ADDR_LOCK,    8'h01, 3'd0, 0, 0, 8'h00);
    add_row(REQ_WRITE, ADDR_LOCK,    8'h02, 3'd0, 0, 0, 8'h00);  // sets the lock bit
    add_row(REQ_WRITE, ADDR_LOCK,    8'h01, 3'd0, 0, 0, 8'h00);  // must be dropped
    add_row(REQ_READ,  ADDR_LOCK,    8'h00, 3'd0, 0, 1, 8'h02);
    add_row(REQ_WRITE, route_addr(0), 8'h05, 3'd0, 0, 0, 8'h00);
    add_row(REQ_WRITE, route_addr(1), 8'h08, 3'd0, 0, 0, 8'h00); // IRQ 8 not routable
    add_row(REQ_WRITE, route_addr(7), 8'h7f, 3'd0, 0, 0, 8'h00);
    add_row(REQ_LEVEL, 8'h00,        8'h00, 3'd0, 1, 0, 8'h00);
    add_row(REQ_LEVEL, 8'hff,        8'hff, 3'd1, 1, 0, 8'h00);
    add_row(REQ_LEVEL, 8'h00,        8'h00, 3'd7, 1, 0, 8'h00);
    add_row(REQ_WRITE, ADDR_CMOS,    8'hff, 3'd0, 0, 0, 8'h00);
    add_row(REQ_WRITE, ADDR_CMOS,    8'h00, 3'd0, 0, 0, 8'h00);  // locks stay set
    add_row(REQ_SPARE, 8'hff,        8'hff, 3'd7, 1, 0, 8'h00);
    add_row(REQ_WRITE, ADDR_ACPI_EN, 8'hff, 3'd0, 0, 0, 8'h00);
    add_row(REQ_WRITE, ADDR_GPIO_LO, 8'hff, 3'd0, 0, 0, 8'h00);
    add_row(REQ_WRITE, ADDR_GPIO_HI, 8'hff, 3'd0, 0, 0, 8'h00);
    add_row(REQ_WRITE, ADDR_GPIO_EN, 8'hff, 3'd0, 0, 0, 8'h00);
    add_row(REQ_LEVEL, 8'h00,        8'h00, 3'd0, 0, 0, 8'h00);

    hot = '{ADDR_ACPI_LO, ADDR_ACPI_HI, ADDR_ACPI_EN, ADDR_LOCK, ADDR_GPIO_LO,
            ADDR_GPIO_HI, ADDR_GPIO_EN, ADDR_CMOS};
    for (int i = 0; i < 8; i++) hot.push_back(route_addr(i));

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[k])
      send_transfer(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].rd);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      quiet = (k >= RANDOM_ITEMS - QUIET_TAIL);
      t = lpcb_in_t'($urandom);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6:   t.req_type = REQ_WRITE;
        7, 8, 9, 10, 11, 12:   t.req_type = REQ_READ;
        13, 14, 15, 16, 17, 18: t.req_type = REQ_LEVEL;
        default:               t.req_type = REQ_SPARE;
      endcase
      // half the time the bytes that steer routing and status, else anywhere
      if ($urandom_range(0, 1) == 0) t.reg_address = hot[$urandom_range(0, hot.size() - 1)];
      send_transfer(t, 1'b0, 8'h00);
    end
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lpcb_pkg.sv
hw/rtl/lpcb_cfg_space.sv
hw/rtl/lpcb_pirq_router.sv
hw/rtl/lpc_bridge_config_and_pirq_router.sv
sim/testbench.sv
